[hw/rtl/itp_pkg.sv]
// Shared types, character codes and helper functions for the infix to postfix converter.
package itp_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);

  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;

  typedef enum logic [2:0] {
    CLS_END,
    CLS_DIGIT,
    CLS_LETTER,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OP
  } cls_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_OVERFLOW,
    ERR_UNMATCHED
  } err_e;

  typedef enum logic [1:0] {
    SEL_SPACE,
    SEL_CH,
    SEL_TOP,
    SEL_NUL
  } emit_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPACE,
    ST_RUN,
    ST_POP_SP,
    ST_LETTER_SP
  } ctl_state_e;

  typedef struct packed {
    logic      load;
    logic      emit;
    emit_sel_e emit_sel;
    logic      emit_last;
    logic      pop;
    logic      push;
    logic      set_num;
    logic      clr_num;
    logic      clear_all;
  } itp_cmd_t;

  typedef struct packed {
    logic in_digit;
    logic in_number;
    cls_e cls;
    logic pop_cond;
    logic count_nz;
    logic out_free;
  } itp_sts_t;

  function automatic cls_e classify(input logic kind, input logic [7:0] ch);
    cls_e cls;
    if (kind) begin
      cls = CLS_END;
    end else if (ch inside {[CH_0:CH_9]}) begin
      cls = CLS_DIGIT;
    end else if (ch inside {[CH_UC_A:CH_UC_Z], [CH_LC_A:CH_LC_Z]}) begin
      cls = CLS_LETTER;
    end else if (ch == CH_LPAREN) begin
      cls = CLS_OPEN;
    end else if (ch == CH_RPAREN) begin
      cls = CLS_CLOSE;
    end else begin
      cls = CLS_OP;
    end
    return cls;
  endfunction

  function automatic logic signed [2:0] prec_of(input logic [7:0] ch);
    logic signed [2:0] p;
    if (ch == CH_CARET) begin
      p = 3'sd3;
    end else if (ch inside {CH_STAR, CH_SLASH}) begin
      p = 3'sd2;
    end else if (ch inside {CH_PLUS, CH_MINUS}) begin
      p = 3'sd1;
    end else begin
      p = -3'sd1;
    end
    return p;
  endfunction

  // True when the stack top must be popped before the item can proceed.
  function automatic logic pop_check(input cls_e cls, input logic [7:0] ch,
                                     input logic [7:0] top, input logic nz);
    logic signed [2:0] pt;
    logic signed [2:0] pc;
    logic              p;
    pt = prec_of(top);
    pc = prec_of(ch);
    case (cls)
      CLS_END:   p = nz;
      CLS_CLOSE: p = nz && (top != CH_LPAREN);
      CLS_OP:    p = nz && ((pt > pc) || ((pt == pc) && (ch != CH_CARET)));
      default:   p = 1'b0;
    endcase
    return p;
  endfunction

endpackage

[hw/rtl/itp_datapath.sv]
// Datapath: operator stack, digit-run flag, sticky error and result register.
module itp_datapath import itp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       kind_i,
  input  logic [7:0] ch_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [7:0] out_char_o,
  output logic       last_o,
  output logic [1:0] error_o,
  input  itp_cmd_t   cmd_i,
  output itp_sts_t   sts_o
);

  logic [7:0]       stack_q [STACK_DEPTH];
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] paren_q, paren_d;
  logic [CNT_W-1:0] cnt_m1;
  logic             num_q, num_d;
  err_e             err_q, err_d;
  cls_e             cls_q;
  logic [7:0]       ch_q;
  logic             out_valid_q;
  logic [7:0]       out_char_q;
  logic             out_last_q;
  err_e             out_err_q;

  logic [7:0] top;
  logic       nz;
  logic       full;
  cls_e       cls_in;
  logic       pop_in;
  logic [7:0] emit_char;

  assign cnt_m1 = count_q - CNT_W'(1);
  assign top    = stack_q[cnt_m1[IDX_W-1:0]];
  assign nz     = (count_q != '0);
  assign full   = (count_q == CNT_W'(STACK_DEPTH));
  assign cls_in = classify(kind_i, ch_i);
  assign pop_in = pop_check(cls_in, ch_i, top, nz);

  always_comb begin
    case (cmd_i.emit_sel)
      SEL_SPACE: emit_char = CH_SPACE;
      SEL_CH:    emit_char = ch_q;
      SEL_TOP:   emit_char = top;
      SEL_NUL:   emit_char = CH_NUL;
      default:   emit_char = CH_NUL;
    endcase
  end

  always_comb begin
    count_d = count_q;
    paren_d = paren_q;
    num_d   = num_q;
    err_d   = err_q;
    // Errors are known at load time so every result of the item carries them.
    if (cmd_i.load && (err_q == ERR_NONE)) begin
      if ((cls_in == CLS_CLOSE) && (paren_q == '0)) begin
        err_d = ERR_UNMATCHED;
      end else if (((cls_in == CLS_OPEN) || (cls_in == CLS_OP)) && full && !pop_in) begin
        err_d = ERR_OVERFLOW;
      end
    end
    if (cmd_i.pop) begin
      count_d = cnt_m1;
      if (top == CH_LPAREN) begin
        paren_d = paren_q - CNT_W'(1);
      end
    end
    if (cmd_i.push && !full) begin
      count_d = count_q + CNT_W'(1);
      if (cls_q == CLS_OPEN) begin
        paren_d = paren_q + CNT_W'(1);
      end
    end
    if (cmd_i.set_num) begin
      num_d = 1'b1;
    end
    if (cmd_i.clr_num) begin
      num_d = 1'b0;
    end
    if (cmd_i.clear_all) begin
      count_d = '0;
      paren_d = '0;
      num_d   = 1'b0;
      err_d   = ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      paren_q     <= '0;
      num_q       <= 1'b0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      paren_q <= paren_d;
      num_q   <= num_d;
      err_q   <= err_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cls_q <= cls_in;
      ch_q  <= ch_i;
    end
    if (cmd_i.push && !full) begin
      stack_q[count_q[IDX_W-1:0]] <= ch_q;
    end
    if (cmd_i.emit) begin
      out_char_q <= emit_char;
      out_last_q <= cmd_i.emit_last;
      out_err_q  <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = out_last_q;
  assign error_o     = out_err_q;

  assign sts_o.in_digit  = (cls_in == CLS_DIGIT);
  assign sts_o.in_number = num_q;
  assign sts_o.cls       = cls_q;
  assign sts_o.pop_cond  = pop_check(cls_q, ch_q, top, nz);
  assign sts_o.count_nz  = nz;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

[hw/rtl/itp_ctrl.sv]
// Controller: sequences the pops and emitted characters of one item.
module itp_ctrl import itp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  itp_sts_t sts_i,
  output itp_cmd_t cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (sts_i.in_number && !sts_i.in_digit) ? ST_SPACE : ST_RUN;
        end
      end
      ST_SPACE: begin
        // Close the digit run; last only if the item adds nothing of its own.
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = SEL_SPACE;
          cmd_o.emit_last = (sts_i.cls != CLS_END) && (sts_i.cls != CLS_LETTER)
                            && (sts_i.cls != CLS_DIGIT) && !sts_i.pop_cond;
          cmd_o.clr_num   = 1'b1;
          state_d         = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts_i.pop_cond) begin
          if (sts_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = SEL_TOP;
            cmd_o.pop      = 1'b1;
            state_d        = ST_POP_SP;
          end
        end else begin
          case (sts_i.cls)
            CLS_END: begin
              if (sts_i.out_free) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_sel  = SEL_NUL;
                cmd_o.emit_last = 1'b1;
                cmd_o.clear_all = 1'b1;
                state_d         = ST_IDLE;
              end
            end
            CLS_DIGIT: begin
              if (sts_i.out_free) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_sel  = SEL_CH;
                cmd_o.emit_last = 1'b1;
                cmd_o.set_num   = 1'b1;
                state_d         = ST_IDLE;
              end
            end
            CLS_LETTER: begin
              if (sts_i.out_free) begin
                cmd_o.emit     = 1'b1;
                cmd_o.emit_sel = SEL_CH;
                state_d        = ST_LETTER_SP;
              end
            end
            CLS_CLOSE: begin
              // Drop the matching open parenthesis if one is there.
              cmd_o.pop = sts_i.count_nz;
              state_d   = ST_IDLE;
            end
            default: begin
              cmd_o.push = 1'b1;
              state_d    = ST_IDLE;
            end
          endcase
        end
      end
      ST_POP_SP: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = SEL_SPACE;
          cmd_o.emit_last = !sts_i.pop_cond && (sts_i.cls != CLS_END);
          state_d         = ST_RUN;
        end
      end
      ST_LETTER_SP: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = SEL_SPACE;
          cmd_o.emit_last = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/infix_to_postfix_converter.sv]
// Top level of the shunting-yard infix to postfix converter.
// Input channel (in_valid_i/in_ready_o): one item per expression character
// (kind_i = 0, ch_i) or an end of expression (kind_i = 1).
// Output channel (out_valid_o/out_ready_i): zero or more postfix characters per item,
// with last_o on the final result of an input item and error_o holding the
// sticky error (none, stack overflow, unmatched close parenthesis).
// One item is worked on at a time: the item is taken, then the controller
// emits its characters one after another through the single result register
// and finishes a push or a discard.
// Every result is registered before it appears on the output.
// Reset empties the stack and clears the digit-run flag and the error.
// When the receiver stalls, the result register holds and the sequencer waits;
// no new item is taken until the current one is done.
module infix_to_postfix_converter import itp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  input  logic [7:0] ch_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       last_o,
  output logic [1:0] error_o
);

  itp_cmd_t cmd;
  itp_sts_t sts;

  itp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kind_i      (kind_i),
    .ch_i        (ch_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_char_o  (out_char_o),
    .last_o      (last_o),
    .error_o     (error_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

[sim/infix_to_postfix_converter_tb.sv]
// Self-checking testbench for the infix to postfix converter: directed and random expressions.
`timescale 1ns / 100ps

module infix_to_postfix_converter_tb;
  import itp_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 410;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic [1:0] err;
  } postfix_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       kind_i      = 1'b0;
  logic [7:0] ch_i        = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_char_o;
  logic       last_o;
  logic [1:0] error_o;

  // Predictor state
  logic [7:0] op_stk [STACK_DEPTH];
  int         stk_cnt  = 0;
  bit         num_open = 1'b0;
  err_e       stk_err  = ERR_NONE;

  postfix_t postfix_q [$];
  int       fail_cnt   = 0;
  int       items_sent = 0;
  int       hold_left  = 0;
  bit       quiet      = 1'b0;

  infix_to_postfix_converter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .ch_i        (ch_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_o      (last_o),
    .error_o     (error_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int op_rank(input logic [7:0] c);
    if (c == CH_CARET) return 3;
    if (c == CH_STAR || c == CH_SLASH) return 2;
    if (c == CH_PLUS || c == CH_MINUS) return 1;
    return -1;
  endfunction

  function automatic void flag_error(input err_e code);
    if (stk_err == ERR_NONE) stk_err = code;
  endfunction

  // Work out the postfix characters one item produces and queue them.
  task automatic predict_postfix(input logic k, input logic [7:0] c);
    logic [7:0] chars [$];
    logic       is_digit;
    int         pc;
    err_e       err_now;
    postfix_t   r;
    is_digit = !k && c >= CH_0 && c <= CH_9;
    if (num_open && !is_digit) begin
      chars.push_back(CH_SPACE);
      num_open = 1'b0;
    end
    if (k) begin
      while (stk_cnt > 0) begin
        stk_cnt--;
        chars.push_back(op_stk[stk_cnt]);
        chars.push_back(CH_SPACE);
      end
      chars.push_back(CH_NUL);
    end else if (is_digit) begin
      chars.push_back(c);
      num_open = 1'b1;
    end else if ((c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z)) begin
      chars.push_back(c);
      chars.push_back(CH_SPACE);
    end else if (c == CH_LPAREN) begin
      if (stk_cnt >= STACK_DEPTH) flag_error(ERR_OVERFLOW);
      else begin
        op_stk[stk_cnt] = c;
        stk_cnt++;
      end
    end else if (c == CH_RPAREN) begin
      while (stk_cnt > 0 && op_stk[stk_cnt - 1] != CH_LPAREN) begin
        stk_cnt--;
        chars.push_back(op_stk[stk_cnt]);
        chars.push_back(CH_SPACE);
      end
      if (stk_cnt > 0) stk_cnt--;
      else flag_error(ERR_UNMATCHED);
    end else begin
      pc = op_rank(c);
      // pop while the top binds tighter; '^' is right associative
      while (stk_cnt > 0 && (op_rank(op_stk[stk_cnt - 1]) > pc ||
             (op_rank(op_stk[stk_cnt - 1]) == pc && c != CH_CARET))) begin
        stk_cnt--;
        chars.push_back(op_stk[stk_cnt]);
        chars.push_back(CH_SPACE);
      end
      if (stk_cnt >= STACK_DEPTH) flag_error(ERR_OVERFLOW);
      else begin
        op_stk[stk_cnt] = c;
        stk_cnt++;
      end
    end
    err_now = stk_err;
    if (k) begin
      stk_cnt  = 0;
      num_open = 1'b0;
      stk_err  = ERR_NONE;
    end
    foreach (chars[i]) begin
      r.ch   = chars[i];
      r.last = (i == chars.size() - 1);
      r.err  = err_now;
      postfix_q.push_back(r);
    end
  endtask

  task automatic check_result();
    postfix_t exp_r;
    if (postfix_q.size() == 0) begin
      $error("unexpected result: out_char %h last %b error %0d", out_char_o, last_o, error_o);
      fail_cnt++;
    end else begin
      exp_r = postfix_q.pop_front();
      if (out_char_o !== exp_r.ch) begin
        $error("out_char: expected %h, got %h", exp_r.ch, out_char_o);
        fail_cnt++;
      end
      if (last_o !== exp_r.last) begin
        $error("last: expected %b, got %b", exp_r.last, last_o);
        fail_cnt++;
      end
      if (error_o !== exp_r.err) begin
        $error("error: expected %0d, got %0d", exp_r.err, error_o);
        fail_cnt++;
      end
    end
  endtask

  // Receiver: check each accepted result, then pick next cycle's ready.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_result();
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= quiet || ($urandom_range(99) >= 14);
    end
  end

  task automatic send_item(input logic k, input logic [7:0] c);
    if (!quiet) begin
      while ($urandom_range(99) < 14) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    ch_i       <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_postfix(k, c);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  // Hold the sender until every queued result has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (postfix_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_operand();
    int n;
    if ($urandom_range(1)) begin
      n = $urandom_range(1, 3);
      repeat (n) send_item(1'b0, 8'($urandom_range(CH_0, CH_9)));
    end else if ($urandom_range(1)) begin
      send_item(1'b0, 8'($urandom_range(CH_UC_A, CH_UC_Z)));
    end else begin
      send_item(1'b0, 8'($urandom_range(CH_LC_A, CH_LC_Z)));
    end
  endtask

  task automatic send_operator();
    logic [7:0] ops [5];
    ops = '{CH_CARET, CH_STAR, CH_SLASH, CH_PLUS, CH_MINUS};
    send_item(1'b0, ops[$urandom_range(0, 4)]);
  endtask

  task automatic test_precedence();
    send_text("A+z*09^(a-Z/b))");
    send_item(1'b1, 8'hFF);
    drain();
  endtask

  task automatic test_odd_chars();
    send_item(1'b0, CH_NUL);
    send_item(1'b0, 8'hFF);
    send_text(" 7!");
    send_item(1'b1, 8'h00);
    drain();
  endtask

  // Seventeen '^' overrun the stack; a digit run then closes on the end item.
  task automatic test_overflow();
    repeat (STACK_DEPTH + 1) send_item(1'b0, CH_CARET);
    send_item(1'b0, 8'(CH_0 + 8'd5));
    send_item(1'b1, 8'h5A);
    drain();
  endtask

  task automatic test_backpressure();
    hold_left = 300;
    send_text("a+b*c-d/e^f");
    send_item(1'b1, 8'h00);
    drain();
  endtask

  task automatic send_random_expr();
    int mode;
    int terms;
    int depth;
    int n;
    mode  = $urandom_range(99);
    depth = 0;
    if (mode < 8) begin
      // raw noise
      n = $urandom_range(1, 8);
      repeat (n) send_item($urandom_range(99) < 12, 8'($urandom_range(0, 255)));
      send_item(1'b1, 8'($urandom_range(0, 255)));
    end else if (mode < 14) begin
      // deep nesting, may overrun the stack
      n = $urandom_range(12, 20);
      repeat (n) send_item(1'b0, CH_LPAREN);
      send_operand();
      n = $urandom_range(0, 22);
      repeat (n) send_item(1'b0, CH_RPAREN);
      send_item(1'b1, 8'($urandom_range(0, 255)));
    end else begin
      terms = $urandom_range(1, 6);
      for (int t = 0; t < terms; t++) begin
        if (t > 0) send_operator();
        while (depth < 4 && $urandom_range(99) < 25) begin
          send_item(1'b0, CH_LPAREN);
          depth++;
        end
        send_operand();
        while (depth > 0 && $urandom_range(99) < 35) begin
          send_item(1'b0, CH_RPAREN);
          depth--;
        end
        if ($urandom_range(99) < 4) send_item(1'b0, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(99) < 85) begin
        while (depth > 0) begin
          send_item(1'b0, CH_RPAREN);
          depth--;
        end
      end
      if ($urandom_range(99) < 8) send_item(1'b0, CH_RPAREN);
      send_item(1'b1, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random();
    int start;
    start = items_sent;
    quiet = 1'b1;
    while (items_sent - start < RANDOM_ITEMS) begin
      if (items_sent - start > 100) quiet = 1'b0;
      send_random_expr();
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_precedence();
    test_odd_chars();
    test_overflow();
    test_backpressure();
    test_random();
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
